### rtl/core/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constants of the signer bitmap decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam int unsigned MAX_SIGNERS = 2048;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FB_W    = 5;
	localparam int unsigned FIRST_W = 11;
	localparam int unsigned VALID_W = 4;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CNT_W   = 12;
	localparam int unsigned HDR_W   = 16;
	localparam int unsigned POS_W   = 19;

	localparam logic [1:0] PH_VERSION  = 2'd0;
	localparam logic [1:0] PH_COUNT_LO = 2'd1;
	localparam logic [1:0] PH_COUNT_HI = 2'd2;
	localparam logic [1:0] PH_PAYLOAD  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_TRUNC = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

	localparam logic RES_CHUNK  = 1'b0;
	localparam logic RES_STATUS = 1'b1;

	localparam logic [VALID_W-1:0] PER_BIN = 4'd8;
	localparam logic [VALID_W-1:0] PER_TER = 4'd5;

	localparam logic [CNT_W-1:0] CNT_SAT  = 12'hFFF;
	localparam logic [HDR_W-1:0] SEEN_SAT = 16'hFFFF;

	// Record progress kept between bytes.
	typedef struct packed {
		logic [1:0]        phase;
		logic              tern;
		logic [HDR_W-1:0]  count;
		logic [HDR_W-1:0]  seen;
		logic [STAT_W-1:0] err;
	} rec_state_t;

	// One result item.
	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  base;
		logic [FB_W-1:0]    fb;
		logic [FIRST_W-1:0] first;
		logic [VALID_W-1:0] valid;
		logic [STAT_W-1:0]  status;
		logic [CNT_W-1:0]   count;
		logic               last;
	} result_t;

endpackage

### rtl/core/sbd_decode.sv
// ----------------------------------------------------------------------------
// sbd_decode
// Combinational decode of one record byte: next record state and results.
// ----------------------------------------------------------------------------
module sbd_decode import sbd_pkg::*; (
	input  rec_state_t        cur,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_bitmap,
	input  logic              mixed_allowed,
	output rec_state_t        nxt,
	output logic              chunk_vld,
	output logic              stat_vld,
	output result_t           chunk,
	output result_t           stat
);

	// Five base-3 digits, least significant first, two bits each.
	// Divide by three as multiply by 171 and shift by 9 (exact below 256).
	function automatic logic [9:0] ternary_digits(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		logic [BYTE_W-1:0] q;
		logic [15:0]       prod;
		logic [BYTE_W-1:0] rem;
		logic [9:0]        dig;
		v   = b;
		dig = '0;
		for (int k = 0; k < 5; k++) begin
			prod = 16'(v) * 16'd171;
			q    = 8'(prod >> 9);
			rem  = v - 8'(q * 8'd3);
			dig[2*k +: 2] = rem[1:0];
			v    = q;
		end
		return dig;
	endfunction

	logic [POS_W-1:0]   first;
	logic [POS_W-1:0]   count_ext;
	logic [POS_W-1:0]   diff;
	logic [VALID_W-1:0] per;
	logic [VALID_W-1:0] valid;
	logic               covered;
	logic               len_ok;
	logic [9:0]         dig;
	logic [BYTE_W-1:0]  base;
	logic [FB_W-1:0]    fb;
	logic [STAT_W-1:0]  st;
	logic [CNT_W-1:0]   cnt_sat;

	always_comb begin
		per       = cur.tern ? PER_TER : PER_BIN;
		first     = cur.tern ? ((POS_W'(cur.seen) << 2) + POS_W'(cur.seen))
		                     : (POS_W'(cur.seen) << 3);
		count_ext = POS_W'(cur.count);
		covered   = count_ext > first;
		diff      = count_ext - first;
		if (!covered) begin
			valid = '0;
		end else if (diff > POS_W'(per)) begin
			valid = per;
		end else begin
			valid = diff[VALID_W-1:0];
		end
		// Exact length: this byte is the last one the count calls for.
		len_ok = covered && (diff <= POS_W'(per));

		dig  = ternary_digits(data_byte);
		base = '0;
		fb   = '0;
		if (cur.tern) begin
			for (int k = 0; k < FB_W; k++) begin
				if (VALID_W'(k) < valid) begin
					base[k] = (dig[2*k +: 2] == 2'd1);
					fb[k]   = (dig[2*k +: 2] == 2'd2);
				end
			end
		end else begin
			for (int k = 0; k < BYTE_W; k++) begin
				base[k] = data_byte[k] && (VALID_W'(k) < valid);
			end
		end
	end

	always_comb begin
		nxt       = cur;
		chunk_vld = 1'b0;
		unique case (cur.phase)
			PH_VERSION: begin
				nxt.tern = (data_byte != '0) && mixed_allowed;
				if (data_byte != '0 && (!mixed_allowed || data_byte != 8'd1)) begin
					nxt.err = ST_BAD;
				end
				nxt.phase = PH_COUNT_LO;
			end
			PH_COUNT_LO: begin
				nxt.count = HDR_W'(data_byte);
				nxt.phase = PH_COUNT_HI;
			end
			PH_COUNT_HI: begin
				nxt.count = {data_byte, cur.count[7:0]};
				if ({data_byte, cur.count[7:0]} > HDR_W'(MAX_SIGNERS)) begin
					nxt.err = ST_BAD;
				end
				nxt.phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				chunk_vld = 1'b1;
				if (cur.seen != SEEN_SAT) begin
					nxt.seen = cur.seen + 1'b1;
				end
			end
			default: ;
		endcase

		cnt_sat = (nxt.count > HDR_W'(CNT_SAT)) ? CNT_SAT : nxt.count[CNT_W-1:0];
		unique case (cur.phase)
			PH_VERSION, PH_COUNT_LO: begin
				st      = ST_TRUNC;
				cnt_sat = '0;
			end
			PH_COUNT_HI: begin
				st = (nxt.err == ST_OK && nxt.count != '0) ? ST_BAD : nxt.err;
			end
			PH_PAYLOAD: begin
				st = (nxt.err == ST_OK && !len_ok) ? ST_BAD : nxt.err;
			end
			default: st = ST_BAD;
		endcase

		stat_vld = end_of_bitmap;
		if (end_of_bitmap) begin
			nxt = '{phase: PH_VERSION, tern: 1'b0, count: '0, seen: '0, err: ST_OK};
		end
	end

	assign chunk = '{kind: RES_CHUNK, base: base, fb: fb,
	                 first: first[FIRST_W-1:0], valid: valid, status: ST_OK,
	                 count: '0, last: !end_of_bitmap};
	assign stat  = '{kind: RES_STATUS, base: '0, fb: '0, first: '0, valid: '0,
	                 status: st, count: cnt_sat, last: 1'b1};

endmodule

### rtl/core/sbd_out_stage.sv
// ----------------------------------------------------------------------------
// sbd_out_stage
// Result register: holds a chunk and a status, sends the chunk first.
// ----------------------------------------------------------------------------
module sbd_out_stage import sbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    chunk_vld,
	input  logic    stat_vld,
	input  result_t chunk,
	input  result_t stat,
	input  logic    take,
	output logic    load_ok,
	output logic    out_vld,
	output result_t out_res,
	output logic    both_pend
);

	logic    pend_chunk_q;
	logic    pend_stat_q;
	result_t chunk_s1;
	result_t stat_s1;
	logic    fire;

	assign out_vld   = pend_chunk_q || pend_stat_q;
	assign out_res   = pend_chunk_q ? chunk_s1 : stat_s1;
	assign fire      = out_vld && take;
	assign both_pend = pend_chunk_q && pend_stat_q;
	// Room for a new byte once the register empties in this cycle.
	assign load_ok   = !out_vld || (fire && !both_pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_chunk_q <= 1'b0;
			pend_stat_q  <= 1'b0;
		end else if (load) begin
			pend_chunk_q <= chunk_vld;
			pend_stat_q  <= stat_vld;
		end else if (fire) begin
			if (pend_chunk_q) begin
				pend_chunk_q <= 1'b0;
			end else begin
				pend_stat_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chunk_s1 <= chunk;
			stat_s1  <= stat;
		end
	end

endmodule

### rtl/core/signer_bitmap_decoder_core.sv
// ----------------------------------------------------------------------------
// signer_bitmap_decoder_core
// Signer bitmap record decoder, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes the record a byte at a time: s_tdata is the byte,
//   s_tlast marks the final byte of a record, s_tuser is the mixed-mode
//   permission, looked at on the version byte only.
//   Master side sends result transfers: m_tuser 0 is a chunk of signer marks,
//   1 the record status; m_tlast is set on the final result of a byte.
//   Each payload byte gives one chunk; the final byte gives a status after
//   its chunk (or alone, for a record that ends in its header). Header bytes
//   give nothing. On a non-zero status the consumer drops the chunks.
// Timing:
//   A result shows on the master side in the cycle after its byte's transfer.
//   One byte per cycle is sustained while results are taken; a final
//   payload byte holds the slave side back, since its two results leave
//   the single result register one per cycle.
// Reset:
//   arst_n clears the record state to "expecting version" and empties the
//   result register. A master-side stall holds the result in the register
//   and backs up the slave side until the result is taken.
// ----------------------------------------------------------------------------
module signer_bitmap_decoder_core import sbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_bitmap
	input  logic        s_tuser,   // mixed_allowed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] base_bits, [12:8] fallback_bits,
	                               // [23:13] first_index, [27:24] valid_bits,
	                               // [29:28] status, [41:30] signer_count,
	                               // [47:42] zero
	output logic        m_tlast,   // last
	output logic        m_tuser    // result_kind
);

	rec_state_t rec_q;
	rec_state_t rec_nxt;
	logic       chunk_vld;
	logic       stat_vld;
	result_t    chunk;
	result_t    stat;
	result_t    out_res;
	logic       s_xfer;
	logic       load_ok;
	logic       both_pend;

	assign s_tready = load_ok;
	assign s_xfer   = s_tvalid && s_tready;

	// Decode the incoming byte against the record state.
	sbd_decode u_decode (
		.cur           (rec_q),
		.data_byte     (s_tdata),
		.end_of_bitmap (s_tlast),
		.mixed_allowed (s_tuser),
		.nxt           (rec_nxt),
		.chunk_vld     (chunk_vld),
		.stat_vld      (stat_vld),
		.chunk         (chunk),
		.stat          (stat)
	);

	// Advance the record state on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '{phase: PH_VERSION, tern: 1'b0, count: '0, seen: '0, err: ST_OK};
		end else if (s_xfer) begin
			rec_q <= rec_nxt;
		end
	end

	// Hold results until the master side takes them.
	sbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s_xfer),
		.chunk_vld (chunk_vld),
		.stat_vld  (stat_vld),
		.chunk     (chunk),
		.stat      (stat),
		.take      (m_tready),
		.load_ok   (load_ok),
		.out_vld   (m_tvalid),
		.out_res   (out_res),
		.both_pend (both_pend)
	);

	assign m_tdata = {6'b0, out_res.count, out_res.status, out_res.valid,
	                  out_res.first, out_res.fb, out_res.base};
	assign m_tlast = out_res.last;
	assign m_tuser = out_res.kind;

	// Two results still queued: no room for another byte.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		both_pend |-> !s_tready)
		else $error("slave side ready while two results are queued");

	// A final byte always yields a result in the next cycle.
	a_end_yields: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("no result after final byte");

	// A status result closes its byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RES_STATUS) |-> m_tlast)
		else $error("status result without last");

	// A chunk never claims more than eight signers.
	a_chunk_width: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == RES_CHUNK) |-> (m_tdata[27:24] <= PER_BIN))
		else $error("chunk valid count above eight");

endmodule

### tb/bitmap_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_result_checker
// Watches both streams of the signer bitmap decoder, decodes every accepted
// byte on its own copy of the record state and compares each result transfer
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module bitmap_result_checker import sbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	output int          mismatches,
	output int          outstanding
);

	rec_state_t  record;
	result_t     predicted_results[$];
	int unsigned result_no;

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input int unsigned got,
	                             input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
			                          result_no, name, got, want));
	endtask

	// Advance the record state by one byte and queue the results it causes.
	task automatic decode_byte(input logic [7:0] data, input logic eor,
	                           input logic mixed);
		result_t     res;
		int unsigned per;
		int unsigned first;
		int unsigned valid;
		int unsigned digits;
		int unsigned need;
		res = '0;
		case (record.phase)
			PH_VERSION: begin
				record.tern = (data != 8'd0) && mixed;
				if (data != 8'd0 && (!mixed || data != 8'd1))
					record.err = ST_BAD;
				record.phase = PH_COUNT_LO;
			end
			PH_COUNT_LO: begin
				record.count = {8'h00, data};
				record.phase = PH_COUNT_HI;
			end
			PH_COUNT_HI: begin
				record.count[15:8] = data;
				if (record.count > MAX_SIGNERS)
					record.err = ST_BAD;
				record.phase = PH_PAYLOAD;
			end
			default: begin
				per   = record.tern ? 32'(PER_TER) : 32'(PER_BIN);
				first = 32'(record.seen) * per;
				valid = 0;
				if (32'(record.count) > first)
					valid = (32'(record.count) - first > per) ? per
					                                          : 32'(record.count) - first;
				res.kind  = RES_CHUNK;
				res.first = first[FIRST_W-1:0];
				res.valid = valid[VALID_W-1:0];
				res.last  = !eor;
				if (record.tern) begin
					// peel ternary digits, lowest first; the residue is never read
					digits = 32'(data);
					for (int k = 0; k < valid; k++) begin
						if (digits % 3 == 1)
							res.base[k] = 1'b1;
						else if (digits % 3 == 2)
							res.fb[k] = 1'b1;
						digits = digits / 3;
					end
				end else begin
					res.base = 8'(32'(data) & ((32'd1 << valid) - 32'd1));
				end
				predicted_results.push_back(res);
				if (record.seen != SEEN_SAT)
					record.seen++;
			end
		endcase

		if (eor) begin
			res = '0;
			res.kind = RES_STATUS;
			res.last = 1'b1;
			if (record.phase != PH_PAYLOAD) begin
				res.status = ST_TRUNC;
			end else begin
				need = record.tern ? (32'(record.count) + 32'd4) / 32'd5
				                   : (32'(record.count) + 32'd7) / 32'd8;
				res.status = record.err;
				if (res.status == ST_OK && 32'(record.seen) != need)
					res.status = ST_BAD;
				res.count = (record.count > CNT_SAT) ? CNT_SAT : record.count[CNT_W-1:0];
			end
			predicted_results.push_back(res);
			record = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			record = '0;
			predicted_results.delete();
			result_no = 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none predicted",
					                          result_no));
				end else begin
					want = predicted_results.pop_front();
					compare_field("result_kind",   m_tuser,        want.kind);
					compare_field("base_bits",     m_tdata[7:0],   want.base);
					compare_field("fallback_bits", m_tdata[12:8],  want.fb);
					compare_field("first_index",   m_tdata[23:13], want.first);
					compare_field("valid_bits",    m_tdata[27:24], want.valid);
					compare_field("status",        m_tdata[29:28], want.status);
					compare_field("signer_count",  m_tdata[41:30], want.count);
					compare_field("last",          m_tlast,        want.last);
				end
				result_no++;
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

### tb/signer_bitmap_decoder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signer_bitmap_decoder_core_test
// Feeds bitmap records to the decoder: a directed set of header faults and
// both payload bases, then random records with a minority of broken ones,
// random stalls on both streams, one long result backpressure and a record
// at the largest legal count. Results are checked by bitmap_result_checker.
// ----------------------------------------------------------------------------
module signer_bitmap_decoder_core_test import sbd_pkg::*; ();

	localparam int RANDOM_ITEMS = 270;
	localparam int QUIET_FROM   = 200;
	localparam int LONG_HOLD    = 400;
	localparam int STUCK_LIMIT  = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int mismatches;
	int outstanding;

	// idle_pct and hold_req are shared between the byte feeder and the result sink
	int          idle_pct = 20;
	bit          hold_req = 1'b0;
	int          bytes_sent;
	int          stuck_cycles = 0;
	logic [7:0]  record_bytes[$];
	logic        record_mixed;

	always #5 clk = ~clk;

	signer_bitmap_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	bitmap_result_checker results_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Offer one byte, maybe after a gap, and hold it until the transfer.
	task automatic send_byte(input logic [7:0] data, input logic eor, input logic mixed);
		if ($urandom_range(1, 100) <= idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= eor;
		s_tuser  <= mixed;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// The mixed flag only counts on the version byte; toggle it elsewhere.
	task automatic send_record();
		for (int i = 0; i < record_bytes.size(); i++)
			send_byte(record_bytes[i], i == record_bytes.size() - 1,
			          (i == 0) ? record_mixed : 1'($urandom_range(0, 1)));
	endtask

	// Drop valid and wait until every predicted result has come out.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly well-formed records with random marks; about a quarter carry a
	// header or length fault.
	task automatic build_record();
		int unsigned pick;
		int unsigned cnt;
		int unsigned need;
		int unsigned len;
		int unsigned ver;
		int unsigned cut;
		bit          tern;
		bit          mixed;
		tern  = 1'($urandom_range(0, 1));
		pick  = $urandom_range(0, 99);
		cnt   = (pick < 5) ? $urandom_range(49, 200) : $urandom_range(0, 48);
		ver   = tern;
		mixed = tern ? 1'b1 : 1'($urandom_range(0, 1));
		need  = tern ? (cnt + 4) / 5 : (cnt + 7) / 8;
		len   = need;
		cut   = 0;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: cut = $urandom_range(1, 3);
				1: begin
					if ($urandom_range(0, 1)) begin
						ver = $urandom_range(2, 255);
					end else begin
						ver   = 1;
						mixed = 1'b0;
					end
				end
				2: begin
					cnt = $urandom_range(MAX_SIGNERS + 1, 65535);
					len = $urandom_range(0, 4);
				end
				3: len = (need > 0) ? $urandom_range(0, need - 1) : 1;
				default: len = need + $urandom_range(1, 3);
			endcase
		end
		record_bytes = '{};
		record_bytes.push_back(ver[7:0]);
		record_bytes.push_back(cnt[7:0]);
		record_bytes.push_back(cnt[15:8]);
		repeat (len) record_bytes.push_back(8'($urandom_range(0, 255)));
		if (cut != 0)
			while (record_bytes.size() > cut) void'(record_bytes.pop_back());
		record_mixed = mixed;
	endtask

	// Result sink: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(1, 100) <= idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: end the run if neither stream moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : byte_feeder
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		s_tuser  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed records: cut headers, both bases, each header fault.
		record_mixed = 1'b0;
		record_bytes = '{8'h00};
		send_record();
		record_bytes = '{8'h00, 8'h11};
		send_record();
		record_bytes = '{8'h00, 8'h08, 8'h00, 8'hA5};
		send_record();
		// base-3, five fallback signers: 242 is the digit string 22222
		record_mixed = 1'b1;
		record_bytes = '{8'h01, 8'h05, 8'h00, 8'hF2};
		send_record();
		// base-3 version while mixed mode is off
		record_mixed = 1'b0;
		record_bytes = '{8'h01, 8'h00, 8'h00};
		send_record();
		record_mixed = 1'b1;
		record_bytes = '{8'hFF, 8'h00, 8'h00};
		send_record();
		// count one above the maximum
		record_mixed = 1'b0;
		record_bytes = '{8'h00, 8'h01, 8'h08};
		send_record();
		// residue above 242, chunks past the count, payload one byte too long
		record_mixed = 1'b1;
		record_bytes = '{8'h01, 8'h03, 8'h00, 8'hFF, 8'h00};
		send_record();
		wait_results_drained();

		// Long result hold-off while a 20-byte payload keeps coming.
		bytes_sent = 0;
		hold_req = 1'b1;
		record_mixed = 1'b0;
		record_bytes = '{8'h00, 8'd160, 8'h00};
		repeat (20) record_bytes.push_back(8'($urandom_range(0, 255)));
		send_record();

		while (bytes_sent < RANDOM_ITEMS) begin
			if (bytes_sent >= QUIET_FROM)
				idle_pct = 0;
			else
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 8;
					default: idle_pct = 30;
				endcase
			build_record();
			send_record();
			if (bytes_sent < QUIET_FROM && $urandom_range(0, 7) == 0)
				wait_results_drained();
		end

		// Largest legal count, base-2.
		record_mixed = 1'b0;
		record_bytes = '{8'h00, 8'h00, 8'h08};
		repeat (256) record_bytes.push_back(8'($urandom_range(0, 255)));
		send_record();

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/sbd_pkg.sv
rtl/core/sbd_decode.sv
rtl/core/sbd_out_stage.sv
rtl/core/signer_bitmap_decoder_core.sv
tb/bitmap_result_checker.sv
tb/signer_bitmap_decoder_core_test.sv
